// ----- hdl/utf8_stream_decoder_defines.svh -----
// assertion macros for the utf8 stream decoder
// used by modules that clock on clk_i and reset on rst_ni
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define USD_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("usd assertion failed");
`define USD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("usd assertion failed");
`else
`define USD_ASSERT_NOW(lbl, pre, post)
`define USD_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ----- hdl/usd_pkg.sv -----
// shared types and constants of the utf8 stream decoder
// no dependencies
`timescale 1ns / 1ps

package usd_pkg;

  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned WIN_BYTES = 4;

  localparam logic [20:0] MIN_CP2 = 21'h00080;
  localparam logic [20:0] MIN_CP3 = 21'h00800;
  localparam logic [20:0] SURR_LO = 21'h0D800;
  localparam logic [20:0] SURR_HI = 21'h0DFFF;
  localparam logic [20:0] MIN_CP4 = 21'h10000;
  localparam logic [20:0] MAX_CP  = 21'h10FFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  byte_length;
    logic        char_valid;
    logic        stream_valid;
    logic [31:0] char_total;
    logic        last_of_run;
  } out_item_t;

  typedef logic [WIN_BYTES-1:0][7:0] win_t;

  typedef struct packed {
    logic        emit;
    logic [2:0]  len;
    logic [20:0] cp;
    logic        ok;
  } seq_res_t;

endpackage

// ----- hdl/usd_seq_decode.sv -----
// decodes the sequence at the head of a byte window
// depends on usd_pkg
`timescale 1ns / 1ps

module usd_seq_decode (
  input  usd_pkg::win_t     win_i,
  input  logic [2:0]        cnt_i,
  input  logic              eos_i,
  output usd_pkg::seq_res_t res_o
);

  logic [7:0]  lead;
  logic [2:0]  need;
  logic [3:1]  cont;
  logic        broken;
  logic        short_seq;
  logic        single;
  logic [20:0] cp2;
  logic [20:0] cp3;
  logic [20:0] cp4;
  logic        ok_full;

  assign lead = win_i[0];

  always_comb begin
    priority if (!lead[7]) begin
      need = 3'd1;
    end else if (lead[7:5] == 3'b110) begin
      need = 3'd2;
    end else if (lead[7:4] == 4'b1110) begin
      need = 3'd3;
    end else if (lead[7:3] == 5'b11110) begin
      need = 3'd4;
    end else begin
      need = 3'd1;
    end
  end

  always_comb begin
    for (int i = 1; i < 4; i++) begin
      cont[i] = (win_i[i][7:6] == 2'b10);
    end
  end

  assign broken = ((need >= 3'd2) && (cnt_i >= 3'd2) && !cont[1])
               || ((need >= 3'd3) && (cnt_i >= 3'd3) && !cont[2])
               || ((need == 3'd4) && (cnt_i == 3'd4) && !cont[3]);
  assign short_seq = (cnt_i < need);
  assign single = (need == 3'd1) || broken || short_seq;

  assign cp2 = {10'd0, lead[4:0], win_i[1][5:0]};
  assign cp3 = {5'd0, lead[3:0], win_i[1][5:0], win_i[2][5:0]};
  assign cp4 = {lead[2:0], win_i[1][5:0], win_i[2][5:0], win_i[3][5:0]};

  always_comb begin
    unique case (need)
      3'd2:    ok_full = (cp2 >= usd_pkg::MIN_CP2);
      3'd3:    ok_full = (cp3 >= usd_pkg::MIN_CP3)
                      && ((cp3 < usd_pkg::SURR_LO) || (cp3 > usd_pkg::SURR_HI));
      3'd4:    ok_full = (cp4 >= usd_pkg::MIN_CP4) && (cp4 <= usd_pkg::MAX_CP);
      default: ok_full = 1'b0;
    endcase
  end

  always_comb begin
    res_o.emit = (cnt_i != 3'd0) && ((need == 3'd1) || broken || eos_i || !short_seq);
    if (single) begin
      res_o.len = 3'd1;
      res_o.cp  = {13'd0, lead};
      res_o.ok  = (need == 3'd1) && !lead[7];
    end else begin
      res_o.len = need;
      res_o.ok  = ok_full;
      unique case (need)
        3'd2:    res_o.cp = cp2;
        3'd3:    res_o.cp = cp3;
        default: res_o.cp = cp4;
      endcase
    end
  end

endmodule

// ----- hdl/usd_char_counter.sv -----
// saturating character count and stream validity flag
// depends on usd_pkg
`timescale 1ns / 1ps

module usd_char_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        inc_i,
  input  logic        ok_i,
  input  logic        clear_i,
  output logic [31:0] total_o,
  output logic        stream_valid_o
);

  localparam int unsigned CW = usd_pkg::COUNT_WIDTH;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] count_inc;
  logic          all_valid_q, all_valid_d;
  logic          valid_inc;
  logic [63:0]   count_ext;

  assign count_inc = (count_q == '1) ? count_q : count_q + CW'(1);
  assign valid_inc = all_valid_q && ok_i;
  assign count_ext = 64'(count_inc);
  assign total_o = count_ext[31:0];
  assign stream_valid_o = valid_inc;

  always_comb begin
    count_d = count_q;
    all_valid_d = all_valid_q;
    if (clear_i) begin
      count_d = '0;
      all_valid_d = 1'b1;
    end else if (inc_i) begin
      count_d = count_inc;
      all_valid_d = valid_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      all_valid_q <= 1'b1;
    end else begin
      count_q <= count_d;
      all_valid_q <= all_valid_d;
    end
  end

endmodule

// ----- hdl/utf8_stream_decoder.sv -----
// utf8 stream decoder: byte window register, head decoder and result register
// results: the byte window register holds accepted bytes, the result register their decoded results
// throughput: 1 item per cycle unless out_stall_i holds; input stalls while output stalls or more sequences wait
// the byte window drains one sequence per cycle through the head decoder while the output is not stalled
// reset: empty window, count zero, stream flag set, no result pending
`timescale 1ns / 1ps
`include "utf8_stream_decoder_defines.svh"

module utf8_stream_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  usd_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output usd_pkg::out_item_t   out_item_o
);

  usd_pkg::win_t      buf_q, buf_d;
  logic [2:0]         cnt_q, cnt_d;
  logic               eos_q, eos_d;
  usd_pkg::out_item_t out_item_q;
  logic               out_valid_q, out_valid_d;

  usd_pkg::seq_res_t  cur;
  usd_pkg::seq_res_t  more;
  usd_pkg::win_t      rest;
  logic [2:0]         rest_cnt;
  usd_pkg::win_t      base;
  logic [2:0]         base_cnt;
  logic               adv;
  logic               emit;
  logic               in_ready;
  logic               accept;
  logic               flush_done;
  logic [31:0]        total;
  logic               stream_ok;

  usd_seq_decode u_cur (
    .win_i (buf_q),
    .cnt_i (cnt_q),
    .eos_i (eos_q),
    .res_o (cur)
  );

  always_comb begin
    logic [2:0] src;
    for (int i = 0; i < 4; i++) begin
      src = 3'(i) + cur.len;
      rest[i] = (src < 3'd4) ? buf_q[src[1:0]] : 8'h00;
    end
  end

  assign rest_cnt = (cnt_q >= cur.len) ? cnt_q - cur.len : 3'd0;

  usd_seq_decode u_more (
    .win_i (rest),
    .cnt_i (rest_cnt),
    .eos_i (eos_q),
    .res_o (more)
  );

  assign adv        = !out_valid_q || !out_stall_i;
  assign emit       = cur.emit && adv;
  assign in_ready   = !cur.emit || (adv && !more.emit);
  assign accept     = in_valid_i && in_ready;
  assign flush_done = emit && eos_q && !more.emit;
  assign in_stall_o = !in_ready;

  assign base     = emit ? rest : buf_q;
  assign base_cnt = emit ? rest_cnt : cnt_q;

  usd_char_counter u_count (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .inc_i          (emit),
    .ok_i           (cur.ok),
    .clear_i        (flush_done),
    .total_o        (total),
    .stream_valid_o (stream_ok)
  );

  always_comb begin
    buf_d = base;
    cnt_d = base_cnt;
    eos_d = (base_cnt != 3'd0) ? eos_q : 1'b0;
    if (accept) begin
      buf_d[base_cnt[1:0]] = in_item_i.data_byte;
      cnt_d = base_cnt + 3'd1;
      eos_d = in_item_i.end_of_stream;
    end
  end

  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      eos_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      eos_q <= eos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (emit) begin
      out_item_q.code_point   <= cur.cp;
      out_item_q.byte_length  <= cur.len;
      out_item_q.char_valid   <= cur.ok;
      out_item_q.stream_valid <= stream_ok;
      out_item_q.char_total   <= total;
      out_item_q.last_of_run  <= !more.emit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `USD_ASSERT_NOW(a_accept_room, accept, base_cnt <= 3'd3)
  `USD_ASSERT_NOW(a_idle_window_fits, !cur.emit, cnt_q <= 3'd3)
  `USD_ASSERT_NOW(a_eos_flushes, eos_q && (cnt_q != 3'd0), cur.emit)
  `USD_ASSERT_NEXT(a_flush_empties, flush_done && !accept, (cnt_q == 3'd0) && !eos_q)
  `USD_ASSERT_NOW(a_bad_char_flag, out_valid_q && !out_item_q.char_valid,
                  !out_item_q.stream_valid)

endmodule
